FILE: hdl/hslrgb_pkg.sv
`default_nettype none

package hslrgb_pkg;

    localparam int unsigned Q_W  = 17;
    localparam int unsigned QP_W = 18;
    localparam int unsigned OP_W = 17;
    localparam int unsigned PR_W = 19;
    localparam int unsigned V_W  = 20;

    localparam logic [Q_W-1:0] ONE_Q        = 17'd65536;
    localparam logic [Q_W-1:0] THIRD_Q      = 17'd21845;
    localparam logic [Q_W-1:0] SIXTH_Q      = 17'd10923;
    localparam logic [Q_W-1:0] HALF_Q       = 17'd32768;
    localparam logic [Q_W-1:0] TWO_THIRDS_Q = 17'd43691;

    localparam int unsigned NUM_CH = 3;
    localparam int unsigned CH_RED   = 0;
    localparam int unsigned CH_GREEN = 1;
    localparam int unsigned CH_BLUE  = 2;

    localparam int unsigned DEPTH = 7;

    typedef enum logic [1:0] {
        SEG_RISE,
        SEG_FLAT,
        SEG_FALL,
        SEG_LOW
    } seg_t;

    typedef struct packed {
        logic en;
        logic vld;
    } stage_ctl_t;

    typedef struct packed {
        logic       grey;
        logic [7:0] lum;
    } grey_t;

endpackage

`default_nettype wire

FILE: hdl/hslrgb_hsl_if.sv
`default_nettype none

interface hslrgb_hsl_if;

    logic       valid;
    logic       ready;
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] luminance;

    modport source (
        output valid,
        output hue,
        output saturation,
        output luminance,
        input  ready
    );

    modport sink (
        input  valid,
        input  hue,
        input  saturation,
        input  luminance,
        output ready
    );

endinterface

`default_nettype wire

FILE: hdl/hslrgb_rgb_if.sv
`default_nettype none

interface hslrgb_rgb_if;

    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (
        output valid,
        output red,
        output green,
        output blue,
        input  ready
    );

    modport sink (
        input  valid,
        input  red,
        input  green,
        input  blue,
        output ready
    );

endinterface

`default_nettype wire

FILE: hdl/hslrgb_front.sv
`default_nettype none

module hslrgb_front
    import hslrgb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire stage_ctl_t       ctl,
    input  wire logic [7:0]       hue,
    input  wire logic [7:0]       saturation,
    input  wire logic [7:0]       luminance,
    output logic      [Q_W-1:0]   t_out [NUM_CH],
    output logic      [QP_W-1:0]  q_out,
    output logic      [Q_W-1:0]   l_out
);

    function automatic logic [Q_W-1:0] to_q(input logic [7:0] x);
        to_q = {1'b0, x, 8'b0} + {9'b0, x} + {16'b0, x[7]};
    endfunction

    // stage 1: scale to q16
    logic [Q_W-1:0] h_reg, s_reg, l_reg;
    logic           hi_reg;

    // stage 2: l*s and hue offsets
    logic [2*Q_W-1:0] ls_full;
    logic [Q_W-1:0]   ls_next, ls_reg;
    logic [QP_W-1:0]  t_red_sum;
    logic [Q_W-1:0]   t_next [NUM_CH];
    logic [Q_W-1:0]   t2_reg [NUM_CH];
    logic [Q_W-1:0]   s2_reg, l2_reg;
    logic             hi2_reg;

    // stage 3: q
    logic [QP_W-1:0] q_next, q_reg;
    logic [Q_W-1:0]  t3_reg [NUM_CH];
    logic [Q_W-1:0]  l3_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            h_reg  <= to_q(hue);
            s_reg  <= to_q(saturation);
            l_reg  <= to_q(luminance);
            hi_reg <= luminance[7];
        end
    end

    always_comb
    begin
        ls_full   = l_reg * s_reg + (2*Q_W)'(32768);
        ls_next   = ls_full[32:16];
        t_red_sum = {1'b0, h_reg} + {1'b0, THIRD_Q};
        if (t_red_sum > {1'b0, ONE_Q})
        begin
            t_next[CH_RED] = Q_W'(t_red_sum - {1'b0, ONE_Q});
        end
        else
        begin
            t_next[CH_RED] = t_red_sum[Q_W-1:0];
        end
        t_next[CH_GREEN] = h_reg;
        if (h_reg < THIRD_Q)
        begin
            t_next[CH_BLUE] = h_reg + ONE_Q - THIRD_Q;
        end
        else
        begin
            t_next[CH_BLUE] = h_reg - THIRD_Q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            ls_reg  <= ls_next;
            t2_reg  <= t_next;
            s2_reg  <= s_reg;
            l2_reg  <= l_reg;
            hi2_reg <= hi_reg;
        end
    end

    always_comb
    begin
        if (hi2_reg)
        begin
            q_next = {1'b0, l2_reg} + {1'b0, s2_reg} - {1'b0, ls_reg};
        end
        else
        begin
            q_next = {1'b0, l2_reg} + {1'b0, ls_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            q_reg  <= q_next;
            t3_reg <= t2_reg;
            l3_reg <= l2_reg;
        end
    end

    assign t_out = t3_reg;
    assign q_out = q_reg;
    assign l_out = l3_reg;

`ifndef NO_ASSERTIONS
    a_scaled_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.en && ctl.vld |=> h_reg <= ONE_Q && s_reg <= ONE_Q && l_reg <= ONE_Q)
        else $error("scaled input beyond full scale");
`endif

endmodule

`default_nettype wire

FILE: hdl/hslrgb_ramp.sv
`default_nettype none

module hslrgb_ramp
    import hslrgb_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire stage_ctl_t      ctl,
    input  wire logic [Q_W-1:0]  t,
    input  wire logic [QP_W-1:0] q,
    input  wire logic [Q_W-1:0]  l,
    output logic      [7:0]      chan
);

    // stage 1: p, q-p, segment, multiplier operand
    logic [QP_W-1:0] two_l;
    logic [QP_W-1:0] p_next, d_next;
    logic [Q_W-1:0]  fall_diff;
    logic [V_W-1:0]  op_wide;
    seg_t            seg_next;
    logic [OP_W-1:0] op_next;

    logic [QP_W-1:0] p_reg, q_reg, d_reg;
    seg_t            seg_reg;
    logic [OP_W-1:0] op_reg;

    // stage 2: product
    logic [QP_W+OP_W-1:0] prod_full;
    logic [PR_W-1:0]      prod_reg;
    logic [QP_W-1:0]      p2_reg, q2_reg;
    seg_t                 seg2_reg;

    // stage 3: ramp value
    logic [V_W-1:0] v_next, v_reg;

    logic [V_W+7:0] scaled;
    logic [11:0]    chan_wide;

    always_comb
    begin
        two_l = {l, 1'b0};
        if (q > two_l)
        begin
            p_next = '0;
        end
        else
        begin
            p_next = two_l - q;
        end
        if (p_next > q)
        begin
            d_next = '0;
        end
        else
        begin
            d_next = q - p_next;
        end
        fall_diff = TWO_THIRDS_Q - t;
        op_wide   = '0;
        if (t < SIXTH_Q)
        begin
            seg_next = SEG_RISE;
            op_wide  = {1'b0, t, 2'b0} + {2'b0, t, 1'b0};
        end
        else if (t < HALF_Q)
        begin
            seg_next = SEG_FLAT;
        end
        else if (t < TWO_THIRDS_Q)
        begin
            seg_next = SEG_FALL;
            op_wide  = {1'b0, fall_diff, 2'b0} + {2'b0, fall_diff, 1'b0};
        end
        else
        begin
            seg_next = SEG_LOW;
        end
        op_next = op_wide[OP_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            p_reg   <= p_next;
            q_reg   <= q;
            d_reg   <= d_next;
            seg_reg <= seg_next;
            op_reg  <= op_next;
        end
    end

    assign prod_full = d_reg * op_reg + (QP_W+OP_W)'(32768);

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            prod_reg <= prod_full[QP_W+OP_W-1:16];
            p2_reg   <= p_reg;
            q2_reg   <= q_reg;
            seg2_reg <= seg_reg;
        end
    end

    always_comb
    begin
        case (seg2_reg)
            SEG_RISE: v_next = V_W'(p2_reg) + V_W'(prod_reg);
            SEG_FALL: v_next = V_W'(p2_reg) + V_W'(prod_reg);
            SEG_FLAT: v_next = V_W'(q2_reg);
            SEG_LOW:  v_next = V_W'(p2_reg);
            default:  v_next = V_W'(p2_reg);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            v_reg <= v_next;
        end
    end

    // v*255 rounded back to 8 bits
    always_comb
    begin
        scaled    = {v_reg, 8'b0} - {8'b0, v_reg} + (V_W+8)'(32768);
        chan_wide = scaled[V_W+7:16];
        if (chan_wide > 12'd255)
        begin
            chan = 8'd255;
        end
        else
        begin
            chan = chan_wide[7:0];
        end
    end

`ifndef NO_ASSERTIONS
    a_p_below_q: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.en && ctl.vld |=> p_reg <= q_reg)
        else $error("ramp low level above high level");

    a_op_segment: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.en && ctl.vld |=> (seg_reg == SEG_RISE || seg_reg == SEG_FALL || op_reg == '0))
        else $error("multiplier operand set outside a slope segment");
`endif

endmodule

`default_nettype wire

FILE: hdl/hsl_to_rgb_converter_core.sv
// throughput: one word per cycle while the output word is taken, set by the pipeline of 7 register stages
// the whole pipeline advances together and holds while the output word is not taken
// reset: rst_n asynchronous active low, clears the valid bits; data registers are not reset
`default_nettype none

module hsl_to_rgb_converter_core
    import hslrgb_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    hslrgb_hsl_if.sink   hsl,
    hslrgb_rgb_if.source rgb
);

    logic [DEPTH-1:0] valid_reg, valid_next;
    logic             en;

    stage_ctl_t front_ctl, ramp_ctl;

    logic [Q_W-1:0]  t_q [NUM_CH];
    logic [QP_W-1:0] q_q;
    logic [Q_W-1:0]  l_q;
    logic [7:0]      chan [NUM_CH];

    grey_t grey_reg [DEPTH-1];
    grey_t grey_next;
    grey_t grey_out;

    logic [7:0] red_reg, green_reg, blue_reg;

    assign en        = !valid_reg[DEPTH-1] || rgb.ready;
    assign hsl.ready = en;

    always_comb
    begin
        valid_next = {valid_reg[DEPTH-2:0], hsl.valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    assign front_ctl = '{en: en, vld: hsl.valid};
    assign ramp_ctl  = '{en: en, vld: valid_reg[2]};

    hslrgb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (front_ctl),
        .hue        (hsl.hue),
        .saturation (hsl.saturation),
        .luminance  (hsl.luminance),
        .t_out      (t_q),
        .q_out      (q_q),
        .l_out      (l_q)
    );

    for (genvar ch = 0; ch < NUM_CH; ch++)
    begin : g_ch
        hslrgb_ramp u_ramp (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ramp_ctl),
            .t     (t_q[ch]),
            .q     (q_q),
            .l     (l_q),
            .chan  (chan[ch])
        );
    end

    // zero saturation bypass travels beside the datapath
    assign grey_next = '{grey: (hsl.saturation == 8'd0), lum: hsl.luminance};
    assign grey_out  = grey_reg[DEPTH-2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            grey_reg[0] <= grey_next;
            for (int i = 1; i < DEPTH-1; i++)
            begin
                grey_reg[i] <= grey_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (grey_out.grey)
            begin
                red_reg   <= grey_out.lum;
                green_reg <= grey_out.lum;
                blue_reg  <= grey_out.lum;
            end
            else
            begin
                red_reg   <= chan[CH_RED];
                green_reg <= chan[CH_GREEN];
                blue_reg  <= chan[CH_BLUE];
            end
        end
    end

    assign rgb.valid = valid_reg[DEPTH-1];
    assign rgb.red   = red_reg;
    assign rgb.green = green_reg;
    assign rgb.blue  = blue_reg;

`ifndef NO_ASSERTIONS
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(valid_reg))
        else $error("pipeline moved during a stall");
`endif

endmodule

`default_nettype wire

FILE: dv/hsl_to_rgb_converter_core_tb.sv
`default_nettype none

module hsl_to_rgb_converter_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import hslrgb_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned STALL_CYCLES   = 300;
    localparam int unsigned STALL_AFTER    = 50;
    localparam int unsigned DRAIN_CYCLES   = 20;
    localparam int unsigned PHASE_ITEMS    = 200;

    localparam longint Q16_ONE      = 65536;
    localparam longint Q16_ROUND    = 32768;
    localparam longint Q16_THIRD    = 21845;
    localparam longint Q16_SIXTH    = 10923;
    localparam longint Q16_HALF     = 32768;
    localparam longint Q16_TWO_THRD = 43691;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] luminance;
    } hsl_word_t;

    typedef struct packed {
        hsl_word_t  src;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_word_t;

    logic clk;
    logic rst_n;

    hslrgb_hsl_if hsl_bus ();
    hslrgb_rgb_if rgb_bus ();

    hsl_to_rgb_converter_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .hsl   (hsl_bus),
        .rgb   (rgb_bus)
    );

    hsl_word_t   pending_hsl[$];
    rgb_word_t   rgb_expected[$];
    hsl_word_t   next_word;
    rgb_word_t   exp_word;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned failures;
    int unsigned results_seen;
    int unsigned stall_left;
    bit          stall_done;
    int unsigned quiet_cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint to_q16(longint x);
        return (2 * x * Q16_ONE + 255) / 510;
    endfunction

    function automatic longint mul_q16(longint a, longint b);
        return (a * b + Q16_ROUND) >> 16;
    endfunction

    function automatic longint hue_ramp(longint p, longint q, longint t);
        longint d;
        d = (q > p) ? q - p : 0;
        if (t < 0)
            t = t + Q16_ONE;
        if (t > Q16_ONE)
            t = t - Q16_ONE;
        if (t < Q16_SIXTH)
            return p + mul_q16(d, 6 * t);
        if (t < Q16_HALF)
            return q;
        if (t < Q16_TWO_THRD)
            return p + mul_q16(d, 6 * (Q16_TWO_THRD - t));
        return p;
    endfunction

    function automatic logic [7:0] to_channel(longint v);
        longint r;
        if (v < 0)
            v = 0;
        r = (v * 255 + Q16_ROUND) >> 16;
        return (r > 255) ? 8'd255 : r[7:0];
    endfunction

    function automatic rgb_word_t predict_rgb(hsl_word_t w);
        rgb_word_t res;
        longint    h;
        longint    s;
        longint    l;
        longint    q;
        longint    p;
        res.src = w;
        if (w.saturation == 8'd0)
        begin
            res.red   = w.luminance;
            res.green = w.luminance;
            res.blue  = w.luminance;
            return res;
        end
        h = to_q16(longint'(w.hue));
        s = to_q16(longint'(w.saturation));
        l = to_q16(longint'(w.luminance));
        if (w.luminance < 8'd128)
            q = l + mul_q16(l, s);
        else
            q = l + s - mul_q16(l, s);
        p = 2 * l - q;
        if (p < 0)
            p = 0;
        res.red   = to_channel(hue_ramp(p, q, h + Q16_THIRD));
        res.green = to_channel(hue_ramp(p, q, h));
        res.blue  = to_channel(hue_ramp(p, q, h - Q16_THIRD));
        return res;
    endfunction

    function automatic hsl_word_t random_hsl();
        hsl_word_t   w;
        logic [7:0]  corners[12];
        corners = '{8'd0, 8'd42, 8'd43, 8'd85, 8'd86, 8'd127,
                    8'd128, 8'd170, 8'd171, 8'd212, 8'd213, 8'd255};
        w.hue        = 8'($urandom_range(0, 255));
        w.saturation = 8'($urandom_range(0, 255));
        w.luminance  = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0: w.saturation = 8'd0;
            1: w.luminance = 8'($urandom_range(126, 129));
            2: w.hue = corners[4'($urandom_range(0, 11))];
            3: w.saturation = $urandom_range(0, 1) ? 8'd255 : 8'd1;
            default: ;
        endcase
        return w;
    endfunction

    task automatic queue_hsl(hsl_word_t w);
        pending_hsl.insert(pending_hsl.size(), w);
    endtask

    task automatic push_hsl(logic [7:0] h, logic [7:0] s, logic [7:0] l);
        hsl_word_t w;
        w.hue        = h;
        w.saturation = s;
        w.luminance  = l;
        queue_hsl(w);
    endtask

    task automatic push_random(int unsigned n);
        repeat (n) queue_hsl(random_hsl());
    endtask

    task automatic drain();
        while (pending_hsl.size() != 0 || hsl_bus.valid || rgb_expected.size() != 0)
            @(negedge clk);
    endtask

    // source side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hsl_bus.valid      <= 1'b0;
            hsl_bus.hue        <= 8'd0;
            hsl_bus.saturation <= 8'd0;
            hsl_bus.luminance  <= 8'd0;
        end
        else
        begin
            if (hsl_bus.valid && hsl_bus.ready)
                rgb_expected.insert(rgb_expected.size(),
                                    predict_rgb('{hue: hsl_bus.hue,
                                                  saturation: hsl_bus.saturation,
                                                  luminance: hsl_bus.luminance}));
            if (!hsl_bus.valid || hsl_bus.ready)
            begin
                if (pending_hsl.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_word = pending_hsl.pop_front();
                    hsl_bus.valid      <= 1'b1;
                    hsl_bus.hue        <= next_word.hue;
                    hsl_bus.saturation <= next_word.saturation;
                    hsl_bus.luminance  <= next_word.luminance;
                end
                else
                begin
                    hsl_bus.valid <= 1'b0;
                end
            end
        end
    end

    // sink side and checking
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rgb_bus.ready <= 1'b0;
            stall_left    = 0;
            stall_done    = 1'b0;
            results_seen  = 0;
            failures      = 0;
        end
        else
        begin
            if (rgb_bus.valid && rgb_bus.ready)
            begin
                results_seen = results_seen + 1;
                if (rgb_expected.size() == 0)
                begin
                    if (failures < 10)
                        $display("unexpected rgb word %0d %0d %0d",
                                 rgb_bus.red, rgb_bus.green, rgb_bus.blue);
                    failures = failures + 1;
                end
                else
                begin
                    exp_word = rgb_expected.pop_front();
                    if (rgb_bus.red !== exp_word.red || rgb_bus.green !== exp_word.green
                        || rgb_bus.blue !== exp_word.blue)
                    begin
                        if (failures < 10)
                            $display({"mismatch hsl %0d %0d %0d: ",
                                      "expected %0d %0d %0d got %0d %0d %0d"},
                                     exp_word.src.hue, exp_word.src.saturation,
                                     exp_word.src.luminance,
                                     exp_word.red, exp_word.green, exp_word.blue,
                                     rgb_bus.red, rgb_bus.green, rgb_bus.blue);
                        failures = failures + 1;
                    end
                end
            end
            if (stall_left != 0)
            begin
                rgb_bus.ready <= 1'b0;
                stall_left = stall_left - 1;
            end
            else if (!stall_done && results_seen >= STALL_AFTER)
            begin
                // long hold-off so the pipeline fills and backs up
                stall_done = 1'b1;
                stall_left = STALL_CYCLES;
                rgb_bus.ready <= 1'b0;
            end
            else
            begin
                rgb_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((hsl_bus.valid && hsl_bus.ready) || (rgb_bus.valid && rgb_bus.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles", quiet_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
        else
        begin
            quiet_cycles <= 0;
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        send_idle_pct      = 10;
        recv_idle_pct      = 79;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // grey, extremes of luminance, both luminance branches, hue breakpoints
        push_hsl(8'd0,   8'd0,   8'd0);
        push_hsl(8'd255, 8'd0,   8'd255);
        push_hsl(8'd100, 8'd0,   8'd77);
        push_hsl(8'd0,   8'd255, 8'd127);
        push_hsl(8'd0,   8'd255, 8'd128);
        push_hsl(8'd255, 8'd255, 8'd255);
        push_hsl(8'd255, 8'd255, 8'd0);
        push_hsl(8'd85,  8'd255, 8'd128);
        push_hsl(8'd170, 8'd255, 8'd127);
        push_hsl(8'd42,  8'd200, 8'd100);
        push_hsl(8'd43,  8'd200, 8'd100);
        push_hsl(8'd86,  8'd200, 8'd180);
        push_hsl(8'd127, 8'd128, 8'd60);
        push_hsl(8'd128, 8'd128, 8'd60);
        push_hsl(8'd171, 8'd1,   8'd128);
        push_hsl(8'd212, 8'd1,   8'd1);
        push_hsl(8'd213, 8'd254, 8'd254);
        push_hsl(8'd1,   8'd255, 8'd1);
        push_hsl(8'd254, 8'd170, 8'd200);
        push_hsl(8'd64,  8'd85,  8'd129);
        push_hsl(8'd192, 8'd127, 8'd126);
        push_hsl(8'd170, 8'd255, 8'd128);
        push_random(PHASE_ITEMS);
        drain();

        send_idle_pct = 79;
        recv_idle_pct = 10;
        push_random(PHASE_ITEMS);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_random(PHASE_ITEMS);
        drain();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && rgb_expected.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
